@@ rtl/jms_pkg.sv @@
`default_nettype none

package jms_pkg;

  // Marker codes
  localparam logic [7:0] BYTE_PREFIX = 8'hFF;
  localparam logic [7:0] BYTE_STUFF  = 8'h00;
  localparam logic [7:0] CODE_SOF0   = 8'hC0;
  localparam logic [7:0] CODE_SOF2   = 8'hC2;
  localparam logic [7:0] CODE_DHT    = 8'hC4;
  localparam logic [7:0] CODE_RST0   = 8'hD0;
  localparam logic [7:0] CODE_RSTMSK = 8'hF8;
  localparam logic [7:0] CODE_SOI    = 8'hD8;
  localparam logic [7:0] CODE_EOI    = 8'hD9;
  localparam logic [7:0] CODE_SOS    = 8'hDA;
  localparam logic [7:0] CODE_DQT    = 8'hDB;
  localparam logic [7:0] CODE_DRI    = 8'hDD;
  localparam logic [7:0] CODE_APP0   = 8'hE0;
  localparam logic [7:0] CODE_APP1   = 8'hE1;
  localparam logic [7:0] CODE_APP2   = 8'hE2;
  localparam logic [7:0] CODE_APP15  = 8'hEF;
  localparam logic [7:0] CODE_COM    = 8'hFE;

  // Marker classes
  localparam logic [3:0] CLS_OTHER = 4'd0;
  localparam logic [3:0] CLS_SOF0  = 4'd1;
  localparam logic [3:0] CLS_SOF2  = 4'd2;
  localparam logic [3:0] CLS_DHT   = 4'd3;
  localparam logic [3:0] CLS_RST   = 4'd4;
  localparam logic [3:0] CLS_SOI   = 4'd5;
  localparam logic [3:0] CLS_EOI   = 4'd6;
  localparam logic [3:0] CLS_SOS   = 4'd7;
  localparam logic [3:0] CLS_DQT   = 4'd8;
  localparam logic [3:0] CLS_DRI   = 4'd9;
  localparam logic [3:0] CLS_APP0  = 4'd10;
  localparam logic [3:0] CLS_APP1  = 4'd11;
  localparam logic [3:0] CLS_APPN  = 4'd12;
  localparam logic [3:0] CLS_COM   = 4'd13;

  // Restart interval status codes
  localparam logic [2:0] IST_NONE    = 3'd0;
  localparam logic [2:0] IST_OK      = 3'd1;
  localparam logic [2:0] IST_NOLEN   = 3'd2;
  localparam logic [2:0] IST_BADLEN  = 3'd3;
  localparam logic [2:0] IST_CUTOFF  = 3'd4;

  // Record kinds
  localparam logic KIND_MARKER  = 1'b0;
  localparam logic KIND_OVERRUN = 1'b1;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  typedef enum logic [2:0] {
    PH_SEEK   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_INT_HI = 3'd4,
    PH_INT_LO = 3'd5,
    PH_SKIP   = 3'd6
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  code;
    logic [31:0] offset;
    logic        has_len;
    logic [15:0] seg_len;
    logic [3:0]  cls;
    logic [15:0] interval;
    logic [2:0]  status;
    logic [15:0] overrun;
    logic        last;
  } rec_t;

  // Results of one input byte: zero, one or two records
  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  function automatic logic is_rst(input logic [7:0] c);
    return (c & CODE_RSTMSK) == CODE_RST0;
  endfunction

  function automatic logic lacks_length(input logic [7:0] c);
    return (c == CODE_SOI) || (c == CODE_EOI) || is_rst(c);
  endfunction

  function automatic logic [3:0] class_of(input logic [7:0] c);
    logic [3:0] k;
    k = CLS_OTHER;
    if (c == CODE_SOF0)                    k = CLS_SOF0;
    else if (c == CODE_SOF2)               k = CLS_SOF2;
    else if (c == CODE_DHT)                k = CLS_DHT;
    else if (is_rst(c))                    k = CLS_RST;
    else if (c == CODE_SOI)                k = CLS_SOI;
    else if (c == CODE_EOI)                k = CLS_EOI;
    else if (c == CODE_SOS)                k = CLS_SOS;
    else if (c == CODE_DQT)                k = CLS_DQT;
    else if (c == CODE_DRI)                k = CLS_DRI;
    else if (c == CODE_APP0)               k = CLS_APP0;
    else if (c == CODE_APP1)               k = CLS_APP1;
    else if (c inside {[CODE_APP2:CODE_APP15]}) k = CLS_APPN;
    else if (c == CODE_COM)                k = CLS_COM;
    return k;
  endfunction

  function automatic rec_t make_rec(input logic kind, input logic [7:0] code,
                                    input logic [31:0] offset, input logic has_len,
                                    input logic [15:0] seg_len,
                                    input logic [15:0] interval,
                                    input logic [2:0] status,
                                    input logic [15:0] overrun);
    rec_t r;
    r.kind     = kind;
    r.code     = code;
    r.offset   = offset;
    r.has_len  = has_len;
    r.seg_len  = has_len ? seg_len : 16'd0;
    r.cls      = class_of(code);
    r.interval = interval;
    r.status   = status;
    r.overrun  = overrun;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/jms_parser.sv @@
`default_nettype none

module jms_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           eos_i,
  input  wire logic           scan_mode_i,
  output jms_pkg::push_t      push_o
);
  import jms_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [7:0]  code_q, code_d;
  logic [31:0] off_q, off_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  ihi_q, ihi_d;
  logic [15:0] skip_q, skip_d;

  logic        skipping;
  logic        is_dri;
  logic [15:0] len_full;
  logic [15:0] seg_size;
  logic [31:0] pos_m1;
  logic        scan_prefix;
  logic [31:0] scan_off;
  logic        scan_emit;
  rec_t        scan_rec;
  rec_t        rec0, rec1;
  logic [1:0]  count;

  assign skipping = !scan_mode_i;
  assign is_dri   = code_q == CODE_DRI;
  assign len_full = {len_q[15:8], byte_i};
  assign seg_size = (len_full < 16'd2) ? 16'd2 : len_full;
  assign pos_m1   = pos_q - 32'd1;

  // Marker search on this byte; after DRI interval bytes a 0xFF high byte opens a prefix
  always_comb begin
    if (phase_q == PH_INT_LO) begin
      scan_prefix = ihi_q == BYTE_PREFIX;
      scan_off    = scan_prefix ? pos_m1 : off_q;
    end else begin
      scan_prefix = phase_q == PH_PREFIX;
      scan_off    = off_q;
    end
    scan_emit = scan_prefix && (byte_i != BYTE_PREFIX) && (byte_i != BYTE_STUFF)
                && (lacks_length(byte_i) || eos_i);
    scan_rec  = make_rec(KIND_MARKER, byte_i, scan_off, 1'b0, 16'd0, 16'd0,
                         (byte_i == CODE_DRI) ? IST_NOLEN : IST_NONE, 16'd0);
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q + 32'd1;
    code_d  = code_q;
    off_d   = off_q;
    len_d   = len_q;
    ihi_d   = ihi_q;
    skip_d  = skip_q;
    case (phase_q)
      PH_LEN_HI: begin
        len_d   = {byte_i, 8'd0};
        phase_d = eos_i ? PH_SEEK : PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = len_full;
        phase_d = PH_SEEK;
        if (is_dri && len_full == 16'd4) begin
          if (!eos_i) phase_d = PH_INT_HI;
        end else if (skipping && !eos_i) begin
          skip_d = seg_size - 16'd2;
          if (seg_size != 16'd2) phase_d = PH_SKIP;
        end
      end
      PH_INT_HI: begin
        ihi_d   = byte_i;
        phase_d = eos_i ? PH_SEEK : PH_INT_LO;
      end
      PH_SKIP: begin
        phase_d = PH_SEEK;
        if (!eos_i) begin
          skip_d = skip_q - 16'd1;
          if (skip_q != 16'd1) phase_d = PH_SKIP;
        end
      end
      default: begin
        // Seek, prefix and the low interval byte; in skip mode that byte only returns to seek
        if (phase_q == PH_INT_LO && skipping) begin
          phase_d = PH_SEEK;
        end else if (!scan_prefix) begin
          if (byte_i == BYTE_PREFIX) begin
            phase_d = PH_PREFIX;
            off_d   = pos_q;
          end else begin
            phase_d = PH_SEEK;
          end
        end else begin
          off_d = scan_off;
          if (byte_i == BYTE_PREFIX) begin
            phase_d = PH_PREFIX;
            off_d   = pos_q;
          end else if (byte_i == BYTE_STUFF) begin
            phase_d = PH_SEEK;
          end else begin
            code_d  = byte_i;
            phase_d = (lacks_length(byte_i) || eos_i) ? PH_SEEK : PH_LEN_HI;
          end
        end
      end
    endcase
    // Stream end returns everything to reset values
    if (eos_i) begin
      phase_d = PH_SEEK;
      pos_d   = 32'd0;
      code_d  = 8'd0;
      off_d   = 32'd0;
      len_d   = 16'd0;
      ihi_d   = 8'd0;
      skip_d  = 16'd0;
    end
  end

  // Result records
  always_comb begin
    rec0  = make_rec(KIND_MARKER, code_q, off_q, 1'b0, 16'd0, 16'd0, IST_NONE, 16'd0);
    rec1  = rec0;
    count = 2'd0;
    case (phase_q)
      PH_LEN_HI: begin
        if (eos_i) begin
          rec0  = make_rec(KIND_MARKER, code_q, off_q, 1'b0, 16'd0, 16'd0,
                           is_dri ? IST_NOLEN : IST_NONE, 16'd0);
          count = 2'd1;
        end
      end
      PH_LEN_LO: begin
        rec1 = make_rec(KIND_OVERRUN, code_q, off_q, 1'b1, len_full, 16'd0, IST_NONE,
                        seg_size - 16'd1);
        if (is_dri && len_full == 16'd4) begin
          rec0 = make_rec(KIND_MARKER, code_q, off_q, 1'b1, len_full, 16'd0,
                          IST_CUTOFF, 16'd0);
          if (eos_i) count = skipping ? 2'd2 : 2'd1;
        end else begin
          rec0  = make_rec(KIND_MARKER, code_q, off_q, 1'b1, len_full, 16'd0,
                           is_dri ? IST_BADLEN : IST_NONE, 16'd0);
          count = (skipping && eos_i) ? 2'd2 : 2'd1;
        end
      end
      PH_INT_HI: begin
        rec0 = make_rec(KIND_MARKER, code_q, off_q, 1'b1, len_q, 16'd0, IST_CUTOFF, 16'd0);
        rec1 = make_rec(KIND_OVERRUN, code_q, off_q, 1'b1, len_q, 16'd0, IST_NONE, 16'd2);
        if (eos_i) count = skipping ? 2'd2 : 2'd1;
      end
      PH_INT_LO: begin
        rec0 = make_rec(KIND_MARKER, code_q, off_q, 1'b1, len_q, {ihi_q, byte_i},
                        IST_OK, 16'd0);
        if (skipping) begin
          rec1  = make_rec(KIND_OVERRUN, code_q, off_q, 1'b1, len_q, 16'd0, IST_NONE,
                           16'd1);
          count = eos_i ? 2'd2 : 2'd1;
        end else begin
          rec1  = scan_rec;
          count = scan_emit ? 2'd2 : 2'd1;
        end
      end
      PH_SKIP: begin
        rec0 = make_rec(KIND_OVERRUN, code_q, off_q, 1'b1, len_q, 16'd0, IST_NONE, skip_q);
        if (eos_i) count = 2'd1;
      end
      default: begin
        rec0  = scan_rec;
        count = scan_emit ? 2'd1 : 2'd0;
      end
    endcase
    // Flag the final record of this byte
    if (count == 2'd2) rec1.last = 1'b1;
    else               rec0.last = 1'b1;
    push_o.count = accept_i ? count : 2'd0;
    push_o.rec0  = rec0;
    push_o.rec1  = rec1;
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      pos_q   <= 32'd0;
      code_q  <= 8'd0;
      off_q   <= 32'd0;
      len_q   <= 16'd0;
      ihi_q   <= 8'd0;
      skip_q  <= 16'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      code_q  <= code_d;
      off_q   <= off_d;
      len_q   <= len_d;
      ihi_q   <= ihi_d;
      skip_q  <= skip_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/jms_result_fifo.sv @@
`default_nettype none

module jms_result_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire jms_pkg::push_t push_i,
  output logic                room_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output jms_pkg::rec_t       rec_o
);
  import jms_pkg::*;

  rec_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, wr_d;
  logic [FifoAw-1:0] rd_q, rd_d;
  logic [FifoAw:0]   cnt_q, cnt_d;
  logic [FifoAw-1:0] wr_p1;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != '0;
  assign rec_o   = mem_q[rd_q];
  // Room for a full pair of records regardless of the consumer
  assign room_o  = cnt_q <= (FifoAw + 1)'(FifoDepth - 2);
  assign wr_p1   = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + FifoAw'(push_i.count);
    rd_d  = rd_q + FifoAw'(pop);
    cnt_d = cnt_q + (FifoAw + 1)'(push_i.count) - (FifoAw + 1)'(pop);
  end

  // Hold record payloads
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q]  <= push_i.rec0;
    if (push_i.count == 2'd2) mem_q[wr_p1] <= push_i.rec1;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/jpeg_marker_segment_scanner.sv @@
`default_nettype none

// JPEG marker segment scanner.
// Input: one stream byte per word on s_axis (tdata = byte, tlast = final byte of
// the stream). Output: one record per word on m_axis; tuser is the record kind
// (0 marker, 1 segment overrun), tlast flags the final record caused by a byte.
// A byte causes zero, one or two records.
// Configuration: cfg_data_i is scan_mode, written when cfg_valid_i is high;
// cfg_ready_o is always high. Write it only while the block is idle.
// Records enter the record queue when their byte is accepted; m_axis offers its oldest one.
// Throughput: one byte per cycle while s_axis_tready is high. Records drain one per
// cycle while m_axis_tready is high from a four-entry record queue; s_axis_tready drops
// while more than two records wait, so a stalled receiver stops the byte stream once three or four records are queued.
// Reset: parser returns to searching for a 0xFF prefix at offset 0, scan_mode
// clears to 0 (skip mode) and the record queue empties. The last byte of a
// stream also returns the parser (not scan_mode) to its reset state.
module jpeg_marker_segment_scanner (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] marker_code, [39:8] marker_offset, [40] has_length,
  // [56:41] segment_length, [60:57] marker_class, [76:61] restart_interval,
  // [79:77] interval_status, [95:80] overrun_bytes
  output logic [95:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // [0] record_kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);
  import jms_pkg::*;

  logic  scan_mode_q;
  logic  accept;
  push_t push;
  rec_t  rec;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      scan_mode_q <= cfg_data_i;
    end
  end

  jms_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .eos_i       (s_axis_tlast),
    .scan_mode_i (scan_mode_q),
    .push_o      (push)
  );

  jms_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .rec_o   (rec)
  );

  // Pack the record onto the output word
  assign m_axis_tdata = {rec.overrun, rec.status, rec.interval, rec.cls, rec.seg_len,
                         rec.has_len, rec.offset, rec.code};
  assign m_axis_tuser = rec.kind;
  assign m_axis_tlast = rec.last;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jms_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 8;

  typedef struct {
    logic        kind;
    logic [7:0]  code;
    logic [31:0] offset;
    logic        has_len;
    logic [15:0] seg_len;
    logic [3:0]  cls;
    logic [15:0] interval;
    logic [2:0]  status;
    logic [15:0] overrun;
    logic        last;
  } marker_rec_t;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } stream_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  // stimulus and expectation stores
  stream_byte_t byte_queue[$];
  logic [7:0]   stream_buf[$];
  marker_rec_t  expected_recs[$];
  marker_rec_t  step_recs[$];
  logic [7:0]   seg_codes[$] = '{CODE_SOF0, CODE_SOF2, CODE_DHT, CODE_SOS, CODE_DQT,
                                 CODE_DRI, CODE_APP0, CODE_APP1, CODE_APP2, CODE_APP15,
                                 CODE_COM, CODE_SOI, CODE_EOI, CODE_RST0};

  // traffic control
  logic send_en = 1'b0;
  logic rx_hold = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  // parser state as the block should hold it
  logic        scan_mode_q = 1'b0;
  phase_e      scan_phase = PH_SEEK;
  logic [31:0] byte_pos = '0;
  logic [7:0]  mark_code = '0;
  logic [31:0] mark_off = '0;
  logic [15:0] seg_len_cap = '0;
  logic [7:0]  intv_high = '0;
  logic [15:0] skip_left = '0;

  jpeg_marker_segment_scanner uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [3:0] marker_class(input logic [7:0] c);
    if (c == CODE_SOF0) return CLS_SOF0;
    if (c == CODE_SOF2) return CLS_SOF2;
    if (c == CODE_DHT) return CLS_DHT;
    if ((c & CODE_RSTMSK) == CODE_RST0) return CLS_RST;
    if (c == CODE_SOI) return CLS_SOI;
    if (c == CODE_EOI) return CLS_EOI;
    if (c == CODE_SOS) return CLS_SOS;
    if (c == CODE_DQT) return CLS_DQT;
    if (c == CODE_DRI) return CLS_DRI;
    if (c == CODE_APP0) return CLS_APP0;
    if (c == CODE_APP1) return CLS_APP1;
    if (c >= CODE_APP2 && c <= CODE_APP15) return CLS_APPN;
    if (c == CODE_COM) return CLS_COM;
    return CLS_OTHER;
  endfunction

  function automatic void add_rec(input logic kind, input logic has_len,
                                  input logic [15:0] interval, input logic [2:0] status,
                                  input logic [15:0] overrun);
    marker_rec_t r;
    r.kind     = kind;
    r.code     = mark_code;
    r.offset   = mark_off;
    r.has_len  = has_len;
    r.seg_len  = has_len ? seg_len_cap : 16'd0;
    r.cls      = marker_class(mark_code);
    r.interval = interval;
    r.status   = status;
    r.overrun  = overrun;
    r.last     = 1'b0;
    step_recs.push_back(r);
  endfunction

  // Hunt for 0xFF and the code after it; fill bytes and stuffing are dropped
  function automatic void hunt_byte(input logic [7:0] b, input logic eos);
    if (scan_phase != PH_PREFIX) begin
      if (b == BYTE_PREFIX) begin
        scan_phase = PH_PREFIX;
        mark_off   = byte_pos;
      end else begin
        scan_phase = PH_SEEK;
      end
    end else if (b == BYTE_PREFIX) begin
      mark_off = byte_pos;
    end else if (b == BYTE_STUFF) begin
      scan_phase = PH_SEEK;
    end else begin
      mark_code = b;
      if (b == CODE_SOI || b == CODE_EOI || (b & CODE_RSTMSK) == CODE_RST0 || eos) begin
        add_rec(KIND_MARKER, 1'b0, 16'd0, (b == CODE_DRI) ? IST_NOLEN : IST_NONE, 16'd0);
        scan_phase = PH_SEEK;
      end else begin
        scan_phase = PH_LEN_HI;
      end
    end
  endfunction

  // Advance the parser by one accepted byte and queue the records it causes
  function automatic void predict_byte(input logic [7:0] b, input logic eos);
    logic        skipping;
    logic        is_dri;
    logic [15:0] seg_span;
    skipping = !scan_mode_q;
    is_dri   = (mark_code == CODE_DRI);
    step_recs.delete();
    case (scan_phase)
      PH_LEN_HI: begin
        seg_len_cap = {b, 8'h00};
        if (eos) begin
          add_rec(KIND_MARKER, 1'b0, 16'd0, is_dri ? IST_NOLEN : IST_NONE, 16'd0);
          scan_phase = PH_SEEK;
        end else begin
          scan_phase = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        seg_len_cap[7:0] = b;
        seg_span = (seg_len_cap < 16'd2) ? 16'd2 : seg_len_cap;
        if (is_dri && seg_len_cap == 16'd4) begin
          if (eos) begin
            add_rec(KIND_MARKER, 1'b1, 16'd0, IST_CUTOFF, 16'd0);
            if (skipping) add_rec(KIND_OVERRUN, 1'b1, 16'd0, IST_NONE, seg_span - 16'd1);
            scan_phase = PH_SEEK;
          end else begin
            scan_phase = PH_INT_HI;
          end
        end else begin
          add_rec(KIND_MARKER, 1'b1, 16'd0, is_dri ? IST_BADLEN : IST_NONE, 16'd0);
          scan_phase = PH_SEEK;
          if (skipping) begin
            if (eos) begin
              add_rec(KIND_OVERRUN, 1'b1, 16'd0, IST_NONE, seg_span - 16'd1);
            end else begin
              skip_left = seg_span - 16'd2;
              if (skip_left != 16'd0) scan_phase = PH_SKIP;
            end
          end
        end
      end
      PH_INT_HI: begin
        intv_high = b;
        if (eos) begin
          add_rec(KIND_MARKER, 1'b1, 16'd0, IST_CUTOFF, 16'd0);
          if (skipping) add_rec(KIND_OVERRUN, 1'b1, 16'd0, IST_NONE, 16'd2);
          scan_phase = PH_SEEK;
        end else begin
          scan_phase = PH_INT_LO;
        end
      end
      PH_INT_LO: begin
        add_rec(KIND_MARKER, 1'b1, {intv_high, b}, IST_OK, 16'd0);
        if (skipping) begin
          if (eos) add_rec(KIND_OVERRUN, 1'b1, 16'd0, IST_NONE, 16'd1);
          scan_phase = PH_SEEK;
        end else begin
          // interval bytes may themselves start a marker in scan mode
          if (intv_high == BYTE_PREFIX) begin
            scan_phase = PH_PREFIX;
            mark_off   = byte_pos - 32'd1;
          end else begin
            scan_phase = PH_SEEK;
          end
          hunt_byte(b, eos);
        end
      end
      PH_SKIP: begin
        if (eos) begin
          add_rec(KIND_OVERRUN, 1'b1, 16'd0, IST_NONE, skip_left);
          scan_phase = PH_SEEK;
        end else begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) scan_phase = PH_SEEK;
        end
      end
      default: hunt_byte(b, eos);
    endcase
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
    foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
    byte_pos = byte_pos + 32'd1;
    // stream end clears everything but the mode
    if (eos) begin
      scan_phase  = PH_SEEK;
      byte_pos    = '0;
      mark_code   = '0;
      mark_off    = '0;
      seg_len_cap = '0;
      intv_high   = '0;
      skip_left   = '0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(15);
    if (r < 2) return BYTE_PREFIX;
    if (r == 2) return BYTE_STUFF;
    return 8'($urandom);
  endfunction

  function automatic void push_marker(input logic [7:0] code);
    stream_buf.push_back(BYTE_PREFIX);
    while ($urandom_range(3) == 0) stream_buf.push_back(BYTE_PREFIX);
    stream_buf.push_back(code);
  endfunction

  // Move the staged stream into the byte queue, flagging its final byte
  function automatic void commit_stream();
    foreach (stream_buf[i]) byte_queue.push_back('{stream_buf[i], i == stream_buf.size() - 1});
  endfunction

  // Build random streams, some cut short: segments, restart definitions, entropy data, noise
  task automatic load_random(input int n_items);
    int          goal;
    int          n;
    int          len;
    logic [7:0]  code;
    logic [15:0] seg_len;
    bit          stop;
    goal = byte_queue.size() + n_items;
    while (byte_queue.size() < goal) begin
      stream_buf.delete();
      stop = 1'b0;
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, 24);
        repeat (n) stream_buf.push_back(rand_byte());
      end else begin
        if ($urandom_range(3) != 0) push_marker(CODE_SOI);
        n = $urandom_range(1, 6);
        repeat (n) begin
          if (!stop) begin
            case ($urandom_range(9))
              0, 1, 2, 3, 4: begin
                if ($urandom_range(4) == 0) code = 8'($urandom);
                else code = seg_codes[$urandom_range(seg_codes.size() - 1)];
                push_marker(code);
                if ($urandom_range(9) == 0) begin
                  // huge length: end the stream inside the payload
                  seg_len = 16'($urandom);
                  len     = $urandom_range(2, 8);
                  stop    = 1'b1;
                end else begin
                  seg_len = 16'($urandom_range(0, 10));
                  len     = seg_len;
                end
                stream_buf.push_back(seg_len[15:8]);
                stream_buf.push_back(seg_len[7:0]);
                for (int i = 2; i < len; i++) stream_buf.push_back(rand_byte());
              end
              5, 6: begin
                push_marker(CODE_DRI);
                seg_len = ($urandom_range(3) != 0) ? 16'd4 : 16'($urandom_range(0, 8));
                stream_buf.push_back(seg_len[15:8]);
                stream_buf.push_back(seg_len[7:0]);
                if (seg_len == 16'd4) begin
                  stream_buf.push_back(($urandom_range(3) == 0) ? BYTE_PREFIX : 8'($urandom));
                  if ($urandom_range(2) == 0) stream_buf.push_back(8'(CODE_RST0 + $urandom_range(9)));
                  else stream_buf.push_back(8'($urandom));
                end else begin
                  for (int i = 2; i < seg_len; i++) stream_buf.push_back(rand_byte());
                end
              end
              default: begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                  stream_buf.push_back(rand_byte());
                  if ($urandom_range(4) == 0) begin
                    stream_buf.push_back(BYTE_PREFIX);
                    stream_buf.push_back(BYTE_STUFF);
                  end
                  if ($urandom_range(5) == 0) push_marker(8'(CODE_RST0 + $urandom_range(7)));
                end
              end
            endcase
          end
        end
        if (!stop && $urandom_range(3) != 0) push_marker(CODE_EOI);
      end
      // cut some streams short at a random point
      if ($urandom_range(4) == 0 && stream_buf.size() > 1) begin
        n = $urandom_range(1, stream_buf.size() - 1);
        while (stream_buf.size() > n) void'(stream_buf.pop_back());
      end
      commit_stream();
    end
  endtask

  task automatic write_scan_mode(input logic mode);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    scan_mode_q = mode;
  endtask

  // Release the loaded bytes, optionally hold off the receiver, then drain
  task automatic run_phase(input int tx_idle, input int rx_stall, input int hold_len);
    @(negedge clk_i);
    tx_idle_pct  = tx_idle;
    rx_stall_pct = rx_stall;
    send_en      = 1'b1;
    if (hold_len > 0) begin
      rx_hold = 1'b1;
      repeat (hold_len) @(negedge clk_i);
      rx_hold = 1'b0;
    end
    do @(negedge clk_i);
    while (byte_queue.size() != 0 || s_axis_tvalid || expected_recs.size() != 0);
    send_en = 1'b0;
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Drive input words from the byte queue; predict each accepted word
  always @(posedge clk_i) begin
    stream_byte_t nxt;
    if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (send_en && byte_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = byte_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tlast  <= nxt.eos;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Check each output word against the oldest expected record
  always @(posedge clk_i) begin
    marker_rec_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_recs.size() == 0) begin
        $display("%0t ns: unexpected record, expected none, actual tdata 0x%0h tuser %0b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = expected_recs.pop_front();
        check_field("record_kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("marker_code", 32'(want.code), 32'(m_axis_tdata[7:0]));
        check_field("marker_offset", want.offset, m_axis_tdata[39:8]);
        check_field("has_length", 32'(want.has_len), 32'(m_axis_tdata[40]));
        check_field("segment_length", 32'(want.seg_len), 32'(m_axis_tdata[56:41]));
        check_field("marker_class", 32'(want.cls), 32'(m_axis_tdata[60:57]));
        check_field("restart_interval", 32'(want.interval), 32'(m_axis_tdata[76:61]));
        check_field("interval_status", 32'(want.status), 32'(m_axis_tdata[79:77]));
        check_field("overrun_bytes", 32'(want.overrun), 32'(m_axis_tdata[95:80]));
        check_field("last_result", 32'(want.last), 32'(m_axis_tlast));
      end
    end
    if (rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // skip mode: SOI, DRI after a fill byte, short length, segment ending on the last byte
    write_scan_mode(1'b0);
    stream_buf = '{BYTE_PREFIX, CODE_SOI, BYTE_PREFIX, BYTE_PREFIX, CODE_DRI, 8'h00, 8'h04,
                   8'h12, 8'h34, BYTE_PREFIX, CODE_SOF0, 8'h00, 8'h01, BYTE_PREFIX,
                   CODE_APP1, 8'h00, 8'h05, 8'h01, 8'h02, 8'h03};
    commit_stream();
    run_phase(0, 0, 0);

    // scan mode: EOI found inside the DRI interval bytes
    write_scan_mode(1'b1);
    stream_buf = '{BYTE_PREFIX, CODE_DRI, 8'h00, 8'h04, BYTE_PREFIX, CODE_EOI};
    commit_stream();
    run_phase(0, 0, 0);

    write_scan_mode(1'b0);
    load_random(450);
    run_phase(84, 0, 0);

    write_scan_mode(1'b1);
    load_random(450);
    run_phase(0, 84, 300);

    write_scan_mode(1'b0);
    load_random(400);
    run_phase(30, 30, 0);

    write_scan_mode(1'b1);
    load_random(450);
    run_phase(0, 0, 0);

    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && expected_recs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ jpeg_marker_segment_scanner.f @@
rtl/jms_pkg.sv
rtl/jms_parser.sv
rtl/jms_result_fifo.sv
rtl/jpeg_marker_segment_scanner.sv
tb/tb_top.sv
